FILE: rtl/rtdc_pkg.sv
// ----------------------------------------------------------------------------
// rtdc_pkg
// Shared types and constants of the RTD code to temperature converter.
// ----------------------------------------------------------------------------
package rtdc_pkg;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_RES = 2'd0,
    REG_NOM_RES = 2'd1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] REF_RES_RST = 20'd43000;
  localparam logic [CFG_W-1:0] NOM_RES_RST = 20'd10000;

  // ratio divider: 3 integer and 32 fraction quotient bits
  localparam int DIV_INT_STEPS = 3;
  localparam int FRAC_Q        = 32;
  localparam int DIV_STEPS     = DIV_INT_STEPS + FRAC_Q;
  localparam int XQ_W          = FRAC_Q + 4;

  // quadratic branch
  localparam logic [28:0]        AB_Q16 = 29'd443522682;
  localparam logic signed [23:0] K_INV  = 24'sd6926407;
  localparam int D_W      = 62;
  localparam logic [63:0] AB_SQ64 = {35'd0, AB_Q16} * {35'd0, AB_Q16};
  localparam logic signed [D_W-1:0] AB_SQ = $signed(AB_SQ64[D_W-1:0]);
  localparam int SQ_W     = 58;
  localparam int SQ_STEPS = 29;
  localparam int S_W      = 29;
  localparam int V_W      = 31;
  localparam int Q_FRAC   = 17;

  // polynomial branch
  localparam int XR_W       = 23;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = ACC_W - 1 + XR_W;
  localparam int POLY_STEPS = 5;
  localparam int POLY_FRAC  = 20;
  localparam logic signed [ACC_W-1:0] POLY_Q20 [POLY_STEPS+1] = '{
    -40'sd253776364, 40'sd233077473, 40'sd27115127,
    -40'sd5060428, -40'sd2955182, 40'sd1598344
  };

  // output
  localparam int T_W  = 19;
  localparam int M_W  = 40;
  localparam logic signed [T_W-1:0] TEMP_MAX = 19'sh3FFFF;
  localparam logic signed [T_W-1:0] TEMP_MIN = 19'sh40000;
  localparam logic [M_W-1:0] TEMP_MAX_MAG = 40'd262143;
  localparam logic [M_W-1:0] TEMP_MIN_MAG = 40'd262144;

  typedef struct packed {
    logic signed [T_W-1:0] temp;
    logic                  poly;
    logic                  sat;
  } out_item_t;

endpackage

FILE: rtl/rtdc_div.sv
// ----------------------------------------------------------------------------
// rtdc_div
// Pipelined restoring divider, one quotient bit per stage, giving the
// resistance ratio in Q32 together with the over-range flag.
// ----------------------------------------------------------------------------
module rtdc_div import rtdc_pkg::*; #(
  parameter int NUM_W = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [NUM_W-1:0] in_den,
  output logic             out_valid,
  output logic [XQ_W-1:0]  out_xq,
  output logic             out_clamp
);

  localparam int RW = NUM_W + 3;

  logic [DIV_STEPS-1:0] valid_r;
  logic [RW-1:0]        rem_r   [DIV_STEPS];
  logic [NUM_W-1:0]     den_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r     [DIV_STEPS];
  logic                 clamp_r [DIV_STEPS];

  logic [RW-1:0]        src_rem   [DIV_STEPS];
  logic [NUM_W-1:0]     src_den   [DIV_STEPS];
  logic [DIV_STEPS-1:0] src_q     [DIV_STEPS];
  logic                 src_clamp [DIV_STEPS];
  logic [RW-1:0]        rem_nxt   [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_nxt     [DIV_STEPS];

  always_comb begin
    logic [RW-1:0] t;
    logic [RW-1:0] d;
    src_rem[0]   = RW'(in_num);
    src_den[0]   = in_den;
    src_q[0]     = '0;
    src_clamp[0] = RW'(in_num) >= {in_den, 3'b000};
    for (int k = 1; k < DIV_STEPS; k++) begin
      src_rem[k]   = rem_r[k-1];
      src_den[k]   = den_r[k-1];
      src_q[k]     = q_r[k-1];
      src_clamp[k] = clamp_r[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k < DIV_INT_STEPS) begin
        t = src_rem[k];
        d = RW'(src_den[k]) << (DIV_INT_STEPS - 1 - k);
      end else begin
        t = src_rem[k] << 1;
        d = RW'(src_den[k]);
      end
      if (t >= d) begin
        rem_nxt[k] = t - d;
        q_nxt[k]   = {src_q[k][DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = t;
        q_nxt[k]   = {src_q[k][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k]   <= rem_nxt[k];
        den_r[k]   <= src_den[k];
        q_r[k]     <= q_nxt[k];
        clamp_r[k] <= src_clamp[k];
      end
    end
  end

  assign out_valid = valid_r[DIV_STEPS-1];
  assign out_clamp = clamp_r[DIV_STEPS-1];
  assign out_xq    = clamp_r[DIV_STEPS-1] ? (XQ_W'(8) << FRAC_Q)
                                          : XQ_W'(q_r[DIV_STEPS-1]);

endmodule

FILE: rtl/rtdc_sqrt.sv
// ----------------------------------------------------------------------------
// rtdc_sqrt
// Pipelined integer square root, one result bit per stage, with side data
// carried alongside.
// ----------------------------------------------------------------------------
module rtdc_sqrt import rtdc_pkg::*; #(
  parameter int SIDE_W = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_val,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [S_W-1:0]    out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic [SQ_STEPS-1:0] valid_r;
  logic [SQ_W-1:0]     v_r    [SQ_STEPS];
  logic [SQ_W-1:0]     res_r  [SQ_STEPS];
  logic [SIDE_W-1:0]   side_r [SQ_STEPS];

  logic [SQ_W-1:0]   src_v    [SQ_STEPS];
  logic [SQ_W-1:0]   src_res  [SQ_STEPS];
  logic [SIDE_W-1:0] src_side [SQ_STEPS];
  logic [SQ_W-1:0]   v_nxt    [SQ_STEPS];
  logic [SQ_W-1:0]   res_nxt  [SQ_STEPS];

  always_comb begin
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] t;
    src_v[0]    = in_val;
    src_res[0]  = '0;
    src_side[0] = in_side;
    for (int k = 1; k < SQ_STEPS; k++) begin
      src_v[k]    = v_r[k-1];
      src_res[k]  = res_r[k-1];
      src_side[k] = side_r[k-1];
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      b = SQ_W'(1) << (SQ_W - 2 - 2 * k);
      t = src_res[k] + b;
      if (src_v[k] >= t) begin
        v_nxt[k]   = src_v[k] - t;
        res_nxt[k] = (src_res[k] >> 1) + b;
      end else begin
        v_nxt[k]   = src_v[k];
        res_nxt[k] = src_res[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[SQ_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        v_r[k]    <= v_nxt[k];
        res_r[k]  <= res_nxt[k];
        side_r[k] <= src_side[k];
      end
    end
  end

  assign out_valid = valid_r[SQ_STEPS-1];
  assign out_root  = res_r[SQ_STEPS-1][S_W-1:0];
  assign out_side  = side_r[SQ_STEPS-1];

endmodule

FILE: rtl/rtdc_poly.sv
// ----------------------------------------------------------------------------
// rtdc_poly
// Pipelined Horner evaluation of the fifth-order polynomial, a multiply
// stage and an add stage for each coefficient below the leading one.
// ----------------------------------------------------------------------------
module rtdc_poly import rtdc_pkg::*; #(
  parameter int SIDE_W = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [XR_W-1:0]         in_xr,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  output logic signed [ACC_W-1:0] out_acc,
  output logic [SIDE_W-1:0]       out_side
);

  logic [POLY_STEPS-1:0]   va_r;
  logic [POLY_STEPS-1:0]   vb_r;
  logic [PROD_W-1:0]       prod_r  [POLY_STEPS];
  logic                    neg_r   [POLY_STEPS];
  logic [XR_W-1:0]         xra_r   [POLY_STEPS];
  logic [SIDE_W-1:0]       sidea_r [POLY_STEPS];
  logic signed [ACC_W-1:0] acc_r   [POLY_STEPS];
  logic [XR_W-1:0]         xrb_r   [POLY_STEPS];
  logic [SIDE_W-1:0]       sideb_r [POLY_STEPS];

  logic signed [ACC_W-1:0] src_acc  [POLY_STEPS];
  logic [XR_W-1:0]         src_xr   [POLY_STEPS];
  logic [SIDE_W-1:0]       src_side [POLY_STEPS];
  logic [POLY_STEPS-1:0]   src_v;
  logic [PROD_W-1:0]       prod_nxt [POLY_STEPS];
  logic signed [ACC_W-1:0] acc_nxt  [POLY_STEPS];

  always_comb begin
    logic [ACC_W-2:0]        m;
    logic signed [ACC_W-1:0] p;
    src_acc[0]  = POLY_Q20[POLY_STEPS];
    src_xr[0]   = in_xr;
    src_side[0] = in_side;
    src_v[0]    = in_valid;
    for (int j = 1; j < POLY_STEPS; j++) begin
      src_acc[j]  = acc_r[j-1];
      src_xr[j]   = xrb_r[j-1];
      src_side[j] = sideb_r[j-1];
      src_v[j]    = vb_r[j-1];
    end
    for (int j = 0; j < POLY_STEPS; j++) begin
      m = src_acc[j][ACC_W-1] ? (ACC_W-1)'(-src_acc[j]) : (ACC_W-1)'(src_acc[j]);
      prod_nxt[j] = PROD_W'(m) * PROD_W'(src_xr[j]);
      p = $signed(ACC_W'(prod_r[j] >> POLY_FRAC));
      acc_nxt[j] = (neg_r[j] ? -p : p) + POLY_Q20[POLY_STEPS-1-j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= '0;
      vb_r <= '0;
    end else if (en) begin
      va_r <= src_v;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < POLY_STEPS; j++) begin
        prod_r[j]  <= prod_nxt[j];
        neg_r[j]   <= src_acc[j][ACC_W-1];
        xra_r[j]   <= src_xr[j];
        sidea_r[j] <= src_side[j];
        acc_r[j]   <= acc_nxt[j];
        xrb_r[j]   <= xra_r[j];
        sideb_r[j] <= sidea_r[j];
      end
    end
  end

  assign out_valid = vb_r[POLY_STEPS-1];
  assign out_acc   = acc_r[POLY_STEPS-1];
  assign out_side  = sideb_r[POLY_STEPS-1];

endmodule

FILE: rtl/rtd_code_to_temperature_top.sv
// ----------------------------------------------------------------------------
// rtd_code_to_temperature_top
// RTD converter word to temperature, Callendar-Van Dusen quadratic with a
// polynomial fallback below zero degrees.
// ----------------------------------------------------------------------------
// usage:
//   in_*   : one request per converter word (bit 0 ignored), valid/ready
//   out_*  : one result per request, in order: temperature in
//            1/2^TEMP_FRAC_BITS degC, polynomial-branch and saturation flags
//   cfg_*  : register writes, index 0 reference and 1 nominal resistance in
//            0.01 ohm; always ready, write only while the pipeline is empty
// pipeline: request to result through the scale stage, divider, discriminant,
//   square root, subtract, polynomial, rounding and output register stages
// throughput: one request per cycle while no stall holds the pipeline, set by
//   the fully pipelined divider, square root and Horner stages
// reset: pipeline and output empty, registers at 430.00 and 100.00 ohm
// stall: a one-entry skid behind the output register takes the item that
//   is in flight; the whole pipeline then holds until the result is taken
// ----------------------------------------------------------------------------
module rtd_code_to_temperature_top import rtdc_pkg::*; #(
  parameter int CODE_BITS      = 15,
  parameter int TEMP_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           in_raw_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [T_W-1:0] out_temperature,
  output logic                  out_used_polynomial,
  output logic                  out_saturated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int NUM_W   = CODE_BITS + CFG_W;
  localparam int SH_Q    = Q_FRAC - TEMP_FRAC_BITS;
  localparam int SH_P    = POLY_FRAC - TEMP_FRAC_BITS;
  localparam int SQ_SIDE = 2 + XR_W;
  localparam int P_SIDE  = 2 + V_W - 1;

  logic [CFG_W-1:0] ref_r, nom_r;
  logic             en;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RES_RST;
      nom_r <= NOM_RES_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_REF_RES: ref_r <= cfg_data;
        REG_NOM_RES: nom_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // scale stage
  logic [CODE_BITS-1:0] code;
  logic [CFG_W-1:0]     r0;
  logic                 fv_r;
  logic [NUM_W-1:0]     num_r, den_r;

  assign code = CODE_BITS'(in_raw_word[15:1]);
  assign r0   = (nom_r == '0) ? CFG_W'(1) : nom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= NUM_W'(code) * NUM_W'(ref_r);
      den_r <= NUM_W'(r0) << CODE_BITS;
    end
  end

  // ratio divider
  logic            dv;
  logic [XQ_W-1:0] xq;
  logic            clamp;

  rtdc_div #(.NUM_W(NUM_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (fv_r),
    .in_num   (num_r),
    .in_den   (den_r),
    .out_valid(dv),
    .out_xq   (xq),
    .out_clamp(clamp)
  );

  // discriminant stage
  logic signed [XQ_W+1:0] dm;
  logic                   dsv_r, clamp_d_r;
  logic signed [D_W-1:0]  d_r;
  logic [XR_W-1:0]        xr_d_r;

  assign dm = $signed({2'b00, XQ_W'(1) << FRAC_Q}) - $signed({2'b00, xq});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dsv_r <= 1'b0;
    end else if (en) begin
      dsv_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r       <= D_W'(K_INV) * D_W'(dm) + AB_SQ;
      xr_d_r    <= xq[XR_W+11:12];
      clamp_d_r <= clamp;
    end
  end

  // square root
  logic               sv;
  logic [S_W-1:0]     root;
  logic [SQ_SIDE-1:0] sq_side;

  rtdc_sqrt #(.SIDE_W(SQ_SIDE)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (dsv_r),
    .in_val   (d_r[D_W-1] ? SQ_W'(0) : d_r[SQ_W-1:0]),
    .in_side  ({d_r[D_W-1], clamp_d_r, xr_d_r}),
    .out_valid(sv),
    .out_root (root),
    .out_side (sq_side)
  );

  // subtract stage
  logic signed [V_W-1:0] v;
  logic                  vv_r, quad_r, clamp_v_r;
  logic [V_W-2:0]        vq_r;
  logic [XR_W-1:0]       xr_v_r;

  assign v = $signed({2'b00, AB_Q16}) - $signed({2'b00, root});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r <= 1'b0;
    end else if (en) begin
      vv_r <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad_r    <= !sq_side[SQ_SIDE-1] && !v[V_W-1];
      clamp_v_r <= sq_side[SQ_SIDE-2];
      vq_r      <= v[V_W-2:0];
      xr_v_r    <= sq_side[XR_W-1:0];
    end
  end

  // polynomial
  logic                    pv;
  logic signed [ACC_W-1:0] acc;
  logic [P_SIDE-1:0]       p_side;

  rtdc_poly #(.SIDE_W(P_SIDE)) u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vv_r),
    .in_xr    (xr_v_r),
    .in_side  ({quad_r, clamp_v_r, vq_r}),
    .out_valid(pv),
    .out_acc  (acc),
    .out_side (p_side)
  );

  // rounding stage
  logic [M_W-1:0] qmag, pmag;
  logic           f_valid_r, fneg_r, fpoly_r, fclamp_r;
  logic [M_W-1:0] fmag_r;

  assign qmag = (M_W'(p_side[V_W-2:0]) + (M_W'(1) << (SH_Q - 1))) >> SH_Q;
  assign pmag = ((acc[ACC_W-1] ? M_W'(-acc) : M_W'(acc)) + (M_W'(1) << (SH_P - 1))) >> SH_P;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fpoly_r  <= !p_side[P_SIDE-1];
      fclamp_r <= p_side[P_SIDE-2];
      fmag_r   <= p_side[P_SIDE-1] ? qmag : pmag;
      fneg_r   <= !p_side[P_SIDE-1] && acc[ACC_W-1];
    end
  end

  // saturation
  out_item_t item;

  always_comb begin
    item.poly = fpoly_r || fclamp_r;
    item.sat  = 1'b0;
    item.temp = fneg_r ? -$signed(fmag_r[T_W-1:0]) : $signed(fmag_r[T_W-1:0]);
    if (fclamp_r || (!fneg_r && fmag_r > TEMP_MAX_MAG)) begin
      item.temp = TEMP_MAX;
      item.sat  = 1'b1;
    end else if (fneg_r && fmag_r > TEMP_MIN_MAG) begin
      item.temp = TEMP_MIN;
      item.sat  = 1'b1;
    end
  end

  // output register and skid
  logic      out_valid_r, skid_valid_r, take;
  out_item_t out_r, skid_r;

  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign take     = en && f_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= take;
        if (take) begin
          out_r <= item;
        end
      end
    end else if (take) begin
      skid_valid_r <= 1'b1;
      skid_r       <= item;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_temperature     = out_r.temp;
  assign out_used_polynomial = out_r.poly;
  assign out_saturated       = out_r.sat;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid filled without an output stall");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_temperature == TEMP_MAX || out_temperature == TEMP_MIN))
    else $error("saturated result not at a range limit");

  a_quad_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_used_polynomial) |-> !out_temperature[T_W-1])
    else $error("quadratic branch gave a negative temperature");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RTD code to temperature converter. Converter
// words go in under random sender gaps and receiver stalls; each result is
// checked field by field against a bit-exact Callendar-Van Dusen predictor.
// The run covers several resistance settings, the extreme ones among them.
// ----------------------------------------------------------------------------
module tb;
  import rtdc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_raw_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [T_W-1:0] out_temperature;
  logic out_used_polynomial;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [CFG_W-1:0] ref_res = REF_RES_RST;
  logic [CFG_W-1:0] nom_res = NOM_RES_RST;
  out_item_t pending_temps[$];
  int mismatches = 0;
  int results_seen = 0;
  int words_sent = 0;
  int poly_seen = 0;
  int sat_seen = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;

  rtd_code_to_temperature_top dut (.*);

  always #4 clk = ~clk;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint round_away(longint v, int sh);
    longint unsigned m;
    m = ((v < 0 ? -v : v) + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic out_item_t convert_word(logic [15:0] raw);
    longint unsigned code, r0, num, den, rem, frac, xq, xr, res, bitv, rv, m;
    longint d, val, acc;
    out_item_t t;
    code = longint'(raw[15:1]);
    r0 = (nom_res == 0) ? 1 : longint'(nom_res);
    num = code * longint'(ref_res);
    den = r0 << 15;
    if (num >= 8 * den) begin
      xq = 64'd8 << 32;
    end else begin
      rem = num % den;
      frac = 0;
      for (int i = 0; i < 32; i++) begin
        rem = rem << 1;
        frac = frac << 1;
        if (rem >= den) begin
          rem -= den;
          frac |= 1;
        end
      end
      xq = ((num / den) << 32) | frac;
    end
    d = longint'(AB_Q16) * longint'(AB_Q16)
        + longint'(K_INV) * ((64'sd1 <<< 32) - longint'(xq));
    val = -1;
    if (d >= 0) begin
      rv = d;
      res = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (rv >= res + bitv) begin
          rv -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      val = longint'(AB_Q16) - longint'(res);
    end
    t.poly = 1'b0;
    t.sat = 1'b0;
    if (val >= 0) begin
      val = round_away(val, 17 - 8);
    end else begin
      t.poly = 1'b1;
      xr = xq >> 12;
      acc = longint'(POLY_Q20[5]);
      for (int i = 4; i >= 0; i--) begin
        m = ((acc < 0 ? -acc : acc) * xr) >> 20;
        acc = (acc < 0 ? -longint'(m) : longint'(m)) + longint'(POLY_Q20[i]);
      end
      val = round_away(acc, 20 - 8);
    end
    if (val > 262143) begin
      val = 262143;
      t.sat = 1'b1;
    end else if (val < -262144) begin
      val = -262144;
      t.sat = 1'b1;
    end
    t.temp = val[T_W-1:0];
    return t;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      int g;
      g = rand_gap();
      out_ready <= (g == 0);
      stall_left <= (g > 0) ? g - 1 : 0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      out_item_t e;
      results_seen++;
      if (pending_temps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result temp=%0d poly=%0b sat=%0b", out_temperature,
                   out_used_polynomial, out_saturated);
      end else begin
        e = pending_temps.pop_front();
        poly_seen += out_used_polynomial;
        sat_seen += out_saturated;
        if (out_temperature !== e.temp || out_used_polynomial !== e.poly ||
            out_saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected temp=%0d poly=%0b sat=%0b, got %0d %0b %0b",
                     results_seen, e.temp, e.poly, e.sat, out_temperature,
                     out_used_polynomial, out_saturated);
        end
      end
    end
  end

  task automatic send_word(logic [15:0] raw);
    int g;
    @(negedge clk);
    in_valid <= 1'b1;
    in_raw_word <= raw;
    do @(posedge clk); while (!in_ready);
    pending_temps.push_back(convert_word(raw));
    words_sent++;
    g = rand_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_REF_RES) ref_res = data;
    else if (idx == REG_NOM_RES) nom_res = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_resistances(logic [CFG_W-1:0] rref, logic [CFG_W-1:0] r0);
    wait_drained();
    write_reg(REG_REF_RES, rref);
    write_reg(REG_NOM_RES, r0);
  endtask

  // extremes of the word and of the ratio at reset settings
  task automatic test_directed_words();
    logic [15:0] words [14] = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE, 16'h0002,
                                16'h2000, 16'h2300, 16'h2500, 16'h3000, 16'h4000,
                                16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF};
    foreach (words[i]) send_word(words[i]);
  endtask

  // zero and full-scale resistances, ignored register index
  task automatic test_register_extremes();
    set_resistances(20'd0, 20'd0);
    send_word(16'h0000);
    send_word(16'hFFFF);
    set_resistances(20'hFFFFF, 20'd1);
    send_word(16'h0002);
    send_word(16'hFFFF);
    set_resistances(20'd1, 20'hFFFFF);
    send_word(16'hFFFF);
    send_word(16'h1234);
    wait_drained();
    write_reg(REG_UNUSED, 20'd777);
    write_reg(REG_UNUSED + 2'd1, 20'd555);
    send_word(16'h8000);
    send_word(16'hC001);
  endtask

  task automatic test_random_words(int count);
    logic [CFG_W-1:0] rref, r0;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0: begin rref = 20'd43000; r0 = 20'd10000; end
        1: begin rref = 20'd40000; r0 = 20'd10000; end
        2: begin rref = 20'd400000; r0 = 20'd100000; end
        3: begin rref = 20'hFFFFF; r0 = CFG_W'($urandom_range(1, 20'hFFFFF)); end
        4: begin rref = CFG_W'($urandom_range(0, 20'hFFFFF)); r0 = 20'd1; end
        default: begin
          rref = CFG_W'($urandom_range(1, 20'hFFFFF));
          r0 = CFG_W'($urandom_range(0, 20'hFFFFF));
        end
      endcase
      set_resistances(rref, r0);
      no_idle = (ph == 2);
      for (int i = 0; i < count / 6; i++) send_word(16'($urandom_range(0, 16'hFFFF)));
      no_idle = 1'b0;
    end
  endtask

  // sender pauses for a full drain, then sends random words under the usual gaps and stalls
  task automatic test_drain_pause();
    set_resistances(REF_RES_RST, NOM_RES_RST);
    for (int i = 0; i < 40; i++) send_word(16'($urandom_range(16'h2000, 16'h3FFF)));
    wait_drained();
    for (int i = 0; i < 40; i++) send_word(16'($urandom_range(0, 16'hFFFF)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_words();
    test_register_extremes();
    test_random_words(2000);
    test_drain_pause();
    wait_drained();
    $display("%0d words converted over several resistance settings", words_sent);
    $display("%0d polynomial-branch results, %0d saturated", poly_seen, sat_seen);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
rtl/rtdc_pkg.sv
rtl/rtdc_div.sv
rtl/rtdc_sqrt.sv
rtl/rtdc_poly.sv
rtl/rtd_code_to_temperature_top.sv
tb/sv/tb.sv
